[rtl/jacobi_stencil_sweep_defines.svh]
// Assertion macros for the Jacobi stencil sweep block.
// Used by the top level only; needs no other file.
`ifndef JACOBI_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_STENCIL_SWEEP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition and consequence in the same cycle.
`define JSS_ASSERT_SAME(label, clk, rst, cond, impl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (impl)) \
      else $error(msg);
// Consequence in the cycle after the condition.
`define JSS_ASSERT_NEXT(label, clk, rst, cond, impl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (impl)) \
      else $error(msg);
`else
`define JSS_ASSERT_SAME(label, clk, rst, cond, impl, msg)
`define JSS_ASSERT_NEXT(label, clk, rst, cond, impl, msg)
`endif
`endif

[rtl/jss_pkg.sv]
// Shared constants, types and register codes of the Jacobi stencil sweep.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package jss_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int LINE_DEPTH  = MAX_COLS + 2;
   localparam int COL_W       = $clog2(LINE_DEPTH);
   localparam int ROW_W       = $clog2(MAX_ROWS + 2);

   localparam int SIZE_W      = 11;
   localparam int THRESH_W    = 31;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int SAMPLE_W    = 32;
   localparam int CHANGE_W    = 31;
   localparam int SUM_W       = SAMPLE_W + 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd2;

   localparam logic [SIZE_W-1:0]   COLS_RESET   = 11'd1024;
   localparam logic [SIZE_W-1:0]   ROWS_RESET   = 11'd1024;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1073742;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CHANGE_W-1:0]        change_type;

   typedef enum logic [1:0] {
      FETCH_IDLE,
      FETCH_OLD,
      FETCH_WINDOW
   } refetch_state_type;

   // Position decode and line buffer addressing for the current request.
   typedef struct packed {
      logic             has_result;
      logic             is_last;
      logic             sweep_end;
      logic             col_zero;
      logic             take_old;
      logic [COL_W-1:0] wr_addr;
      logic [COL_W-1:0] rd_cur_addr;
      logic [COL_W-1:0] rd_above_addr;
   } scan_type;

   // The up, left and right neighbours and the old value of the point being updated.
   typedef struct packed {
      sample_type up;
      sample_type left;
      sample_type right;
      sample_type old;
   } window_type;

   // Contents of the stage between the averaging and the change logic.
   typedef struct packed {
      logic       has_result;
      logic       is_last;
      logic       sweep_end;
      sample_type new_value;
      sample_type old_value;
   } stage_type;

endpackage

`default_nettype wire

[rtl/jss_scan_ctrl.sv]
// Raster position counters, size clamping and line buffer addressing.
// Also holds the refetch sequencer run after a register write. Uses jss_pkg.
`default_nettype none

module jss_scan_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [jss_pkg::SIZE_W-1:0] cfg_cols,
   input  logic [jss_pkg::SIZE_W-1:0] cfg_rows,
   input  logic                       csr_write,
   input  logic                       accept,
   output logic                       busy,
   output jss_pkg::scan_type          scan
);
   import jss_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in, ecols, col_halo, col_pos, col_next, fetch_col;
   logic [ROW_W-1:0]  row_ff, row_in, erows, row_halo, row_pos, row_next;
   logic [COL_W:0]    right_wide;
   logic              fetch_old, take_old;
   refetch_state_type state_ff, state_in;

   always_comb begin
      if (cfg_cols == '0) begin
         ecols = COL_W'(1);
      end else if (int'(cfg_cols) > MAX_COLS) begin
         ecols = COL_W'(MAX_COLS);
      end else begin
         ecols = COL_W'(cfg_cols);
      end
      if (cfg_rows == '0) begin
         erows = ROW_W'(1);
      end else if (int'(cfg_rows) > MAX_ROWS) begin
         erows = ROW_W'(MAX_ROWS);
      end else begin
         erows = ROW_W'(cfg_rows);
      end
   end

   assign col_halo = ecols + COL_W'(1);
   assign row_halo = erows + ROW_W'(1);
   assign col_pos  = (col_ff > col_halo) ? col_halo : col_ff;
   assign row_pos  = (row_ff > row_halo) ? row_halo : row_ff;

   always_comb begin
      if (col_pos == col_halo) begin
         col_next = '0;
         row_next = (row_pos == row_halo) ? '0 : row_pos + ROW_W'(1);
      end else begin
         col_next = col_pos + COL_W'(1);
         row_next = row_pos;
      end
   end

   assign col_in = accept ? col_next : col_ff;
   assign row_in = accept ? row_next : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Next state of the refetch sequencer.
   always_comb begin
      if (csr_write) begin
         state_in = FETCH_OLD;
      end else begin
         case (state_ff)
            FETCH_OLD:    state_in = FETCH_WINDOW;
            FETCH_WINDOW: state_in = FETCH_IDLE;
            FETCH_IDLE:   state_in = FETCH_IDLE;
            default:      state_in = FETCH_IDLE;
         endcase
      end
   end

   // Outputs of the refetch sequencer.
   always_comb begin
      case (state_ff)
         FETCH_OLD: begin
            busy      = 1'b1;
            fetch_old = 1'b1;
            take_old  = 1'b0;
         end
         FETCH_WINDOW: begin
            busy      = 1'b1;
            fetch_old = 1'b0;
            take_old  = 1'b1;
         end
         default: begin
            busy      = 1'b0;
            fetch_old = 1'b0;
            take_old  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FETCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The read ports look one position ahead, so that the data for the next
   // request is waiting in the read registers when it arrives.
   assign fetch_col  = accept ? col_next : col_pos;
   assign right_wide = {1'b0, fetch_col} + (COL_W + 1)'(1);

   always_comb begin
      scan.has_result    = (row_pos >= ROW_W'(2)) && (col_pos != '0) && (col_pos <= ecols);
      scan.is_last       = (row_pos == row_halo) && (col_pos == ecols);
      scan.sweep_end     = (row_pos == row_halo) && (col_pos == col_halo);
      scan.col_zero      = (col_pos == '0);
      scan.take_old      = take_old;
      scan.wr_addr       = col_pos;
      scan.rd_above_addr = fetch_col;
      if (fetch_old) begin
         scan.rd_cur_addr = col_pos;
      end else if (right_wide > (COL_W + 1)'(LINE_DEPTH - 1)) begin
         scan.rd_cur_addr = '0;
      end else begin
         scan.rd_cur_addr = right_wide[COL_W-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/jss_line_buffer.sv]
// Two line memories and the sliding window that feeds the stencil.
// Addressing comes from jss_scan_ctrl; uses jss_pkg.
`default_nettype none

module jss_line_buffer (
   input  logic                clock,
   input  logic                accept,
   input  jss_pkg::sample_type sample,
   input  jss_pkg::scan_type   scan,
   output jss_pkg::window_type window
);
   import jss_pkg::*;

   sample_type line_above_mem   [LINE_DEPTH];
   sample_type line_current_mem [LINE_DEPTH];
   sample_type cur_rd_ff, above_rd_ff, old_ff, left_ff, halo_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         line_current_mem[scan.wr_addr] <= sample;
         line_above_mem[scan.wr_addr]   <= window.old;
      end
      cur_rd_ff   <= line_current_mem[scan.rd_cur_addr];
      above_rd_ff <= line_above_mem[scan.rd_above_addr];
   end

   // The right neighbour of one point is the old value of the next one, and
   // that old value is the left neighbour after it. The first halo column of
   // the previous row is kept aside because no read precedes it.
   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= window.old;
         old_ff  <= cur_rd_ff;
         if (scan.col_zero) begin
            halo_ff <= sample;
         end
      end else if (scan.take_old) begin
         old_ff <= cur_rd_ff;
      end
   end

   always_comb begin
      window.up    = above_rd_ff;
      window.right = cur_rd_ff;
      window.left  = left_ff;
      window.old   = scan.col_zero ? halo_ff : old_ff;
   end

endmodule

`default_nettype wire

[rtl/jss_change_unit.sv]
// Saturated absolute change, running sweep maximum and convergence test.
// Fed by the averaging stage of the top level; uses jss_pkg.
`default_nettype none

module jss_change_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         stage_valid,
   input  jss_pkg::stage_type           stage,
   input  logic [jss_pkg::THRESH_W-1:0] threshold,
   output jss_pkg::change_type          change,
   output jss_pkg::change_type          sweep_max,
   output logic                         converged
);
   import jss_pkg::*;

   logic signed [SAMPLE_W:0] diff_pos, diff_neg;
   logic [SAMPLE_W:0]        mag;
   change_type               running_max_ff, running_max_in;

   // Both differences are formed side by side and the non-negative one kept.
   assign diff_pos = (SAMPLE_W + 1)'(stage.old_value) - (SAMPLE_W + 1)'(stage.new_value);
   assign diff_neg = (SAMPLE_W + 1)'(stage.new_value) - (SAMPLE_W + 1)'(stage.old_value);
   assign mag      = diff_pos[SAMPLE_W] ? diff_neg : diff_pos;
   assign change   = (|mag[SAMPLE_W:CHANGE_W]) ? '1 : mag[CHANGE_W-1:0];

   assign sweep_max = (change > running_max_ff) ? change : running_max_ff;
   assign converged = stage.is_last && (sweep_max < threshold);

   always_comb begin
      running_max_in = running_max_ff;
      if (advance && stage_valid) begin
         if (stage.sweep_end) begin
            running_max_in = '0;
         end else if (stage.has_result) begin
            running_max_in = sweep_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_max_ff <= '0;
      end else begin
         running_max_ff <= running_max_in;
      end
   end

endmodule

`default_nettype wire

[rtl/jacobi_stencil_sweep.sv]
// Top level of the Jacobi five-point stencil sweep: registers, pipeline, outputs.
// Instantiates jss_scan_ctrl, jss_line_buffer and jss_change_unit; uses jss_pkg.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  req     | in        | req_valid/stall    | req_sample
//  rsp     | out       | rsp_valid/stall    | new_value, point_change, sweep_max,
//          |           |                    | last, converged
//  csr     | in        | csr_write          | csr_index, csr_data
//
// One request is taken in every cycle unless req_stall holds it off; a result
// passes the averaging stage register and the result register. After each
// register write the block stalls requests in states FETCH_OLD and FETCH_WINDOW
// while the line memory read ports fetch the window again for the clamped position.
// Reset is synchronous and clears the counters, the running maximum and the
// registers to their defaults; the line memories are not cleared.
// A stalled result still leaves room for one more request in the middle stage.
`default_nettype none
`include "jacobi_stencil_sweep_defines.svh"

module jacobi_stencil_sweep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [jss_pkg::SAMPLE_W-1:0] req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [jss_pkg::SAMPLE_W-1:0] rsp_new_value,
   output logic [jss_pkg::CHANGE_W-1:0]     rsp_point_change,
   output logic [jss_pkg::CHANGE_W-1:0]     rsp_sweep_max,
   output logic                             rsp_last,
   output logic                             rsp_converged,
   input  logic                             csr_write,
   input  logic [jss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jss_pkg::CSR_DATA_W-1:0]   csr_data
);
   import jss_pkg::*;

   logic [SIZE_W-1:0]   cols_ff, rows_ff;
   logic [THRESH_W-1:0] thresh_ff;

   logic                busy, req_accept, advance;
   scan_type            scan;
   window_type          window;
   logic signed [SUM_W-1:0] sum;
   stage_type           stage_ff, stage_in;
   logic                stage_valid_ff, stage_valid_in;

   change_type          change, sweep_max;
   logic                converged;

   logic                rsp_valid_ff;
   sample_type          new_value_ff;
   change_type          point_change_ff, sweep_max_ff;
   logic                last_ff, converged_ff;

   // Configuration registers. Unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= COLS_RESET;
         rows_ff   <= ROWS_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COLS_IN_USE: cols_ff   <= csr_data[SIZE_W-1:0];
            CSR_ROWS_IN_USE: rows_ff   <= csr_data[SIZE_W-1:0];
            CSR_THRESHOLD:   thresh_ff <= csr_data[THRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The result register moves when it is empty or being taken. The middle
   // stage may still fill while the result register waits.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy || (stage_valid_ff && !advance);
   assign req_accept = req_valid && !req_stall;

   jss_scan_ctrl u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg_cols  (cols_ff),
      .cfg_rows  (rows_ff),
      .csr_write (csr_write),
      .accept    (req_accept),
      .busy      (busy),
      .scan      (scan)
   );

   jss_line_buffer u_lines (
      .clock  (clock),
      .accept (req_accept),
      .sample (req_sample),
      .scan   (scan),
      .window (window)
   );

   // Floor of the neighbour average: an arithmetic shift of the exact sum,
   // which always fits the sample width.
   assign sum = SUM_W'(window.up) + SUM_W'(req_sample) + SUM_W'(window.left)
              + SUM_W'(window.right);

   always_comb begin
      stage_in.has_result = scan.has_result;
      stage_in.is_last    = scan.is_last;
      stage_in.sweep_end  = scan.sweep_end;
      stage_in.new_value  = sum[SUM_W-1:2];
      stage_in.old_value  = window.old;
   end

   // Only requests that give a result or close the sweep occupy the stage.
   assign stage_valid_in = (advance || !stage_valid_ff)
                         ? (req_accept && (scan.has_result || scan.sweep_end))
                         : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   jss_change_unit u_change (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage_valid (stage_valid_ff),
      .stage       (stage_ff),
      .threshold   (thresh_ff),
      .change      (change),
      .sweep_max   (sweep_max),
      .converged   (converged)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff && stage_ff.has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         new_value_ff    <= stage_ff.new_value;
         point_change_ff <= change;
         sweep_max_ff    <= sweep_max;
         last_ff         <= stage_ff.is_last;
         converged_ff    <= converged;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_value    = new_value_ff;
   assign rsp_point_change = point_change_ff;
   assign rsp_sweep_max    = sweep_max_ff;
   assign rsp_last         = last_ff;
   assign rsp_converged    = converged_ff;

   // A register write must hold off requests while the window is refetched.
   `JSS_ASSERT_NEXT(a_write_stalls, clock, reset, csr_write, req_stall, "write not stalled")
   // A full middle stage behind a waiting result must stall the request side.
   `JSS_ASSERT_SAME(a_full_stalls, clock, reset, stage_valid_ff && rsp_valid_ff && rsp_stall, req_stall, "overrun of middle stage")
   // The sweep maximum includes the change of the point it comes with.
   `JSS_ASSERT_SAME(a_max_covers, clock, reset, rsp_valid_ff, rsp_sweep_max >= rsp_point_change, "sweep maximum below change")

endmodule

`default_nettype wire
